@@ hw/rtl/ffla_pkg.sv @@
// Shared types and constants for the frame free-list allocator.
// Used by the controller, the datapath, the top level and the checker.
package ffla_pkg;

    localparam int FRAME_W = 10;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_POOL_FIRST = 1'b0,
        CFG_POOL_LAST  = 1'b1
    } t_cfg_idx;

    // One entry of the next-link table.
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_link;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic free_push;
        logic read_head;
        logic pop;
        logic clear_head;
        logic init_load;
        logic sweep;
        logic emit;
        logic fail;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_valid;
        logic pool_empty;
        logic sweep_last;
    } t_dp_status;

endpackage

@@ hw/rtl/ffla_ctrl.sv @@
// Controller state machine of the frame free-list allocator.
// Depends on ffla_pkg; drives the datapath through t_ctrl_cmd.
module ffla_ctrl
    import ffla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_cmd       i_cmd,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_POP   = 3'b010,
        S_SWEEP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd)
                        CMD_ALLOC: begin
                            if (i_status.head_valid) begin
                                o_cmd.read_head = 1'b1;
                                n_state         = S_POP;
                            end else begin
                                o_cmd.emit = 1'b1;
                                o_cmd.fail = 1'b1;
                            end
                        end
                        CMD_FREE: begin
                            o_cmd.free_push = 1'b1;
                            o_cmd.emit      = 1'b1;
                        end
                        CMD_INIT: begin
                            if (i_status.pool_empty) begin
                                o_cmd.clear_head = 1'b1;
                                o_cmd.emit       = 1'b1;
                            end else begin
                                o_cmd.init_load = 1'b1;
                                n_state         = S_SWEEP;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                o_cmd.pop  = 1'b1;
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ hw/rtl/ffla_datapath.sv @@
// Datapath of the frame free-list allocator: pool registers, list head,
// next-link memory, init sweep pointer and result registers. Depends on ffla_pkg.
module ffla_datapath
    import ffla_pkg::*;
#(
    parameter int NUM_FRAMES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [FRAME_W-1:0] i_cfg_data,
    input  logic [FRAME_W-1:0] i_frame_in,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_status,
    output logic               o_done,
    output logic [FRAME_W-1:0] o_frame_out,
    output logic               o_result_status
);

    localparam int AW         = $clog2(NUM_FRAMES);
    localparam int LAST_FRAME = NUM_FRAMES - 1;

    logic [FRAME_W-1:0] r_pool_first;
    logic [FRAME_W-1:0] r_pool_last;
    logic [FRAME_W-1:0] r_head;
    logic               r_head_valid;
    logic [FRAME_W-1:0] r_ptr;
    logic [FRAME_W-1:0] r_hi;
    t_link              r_rd_link;
    logic               r_done;
    logic [FRAME_W-1:0] r_frame_out;
    logic               r_status;

    t_link mem [NUM_FRAMES];

    logic [FRAME_W-1:0] hi_clamped;
    logic               frame_in_range;
    logic               sweep_last;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_link              mem_wdata;

    // The pool end is clamped to the last frame that the table holds.
    assign hi_clamped     = (32'(r_pool_last) > 32'(LAST_FRAME)) ? FRAME_W'(LAST_FRAME)
                                                                 : r_pool_last;
    assign frame_in_range = (32'(i_frame_in) < 32'(NUM_FRAMES));
    assign sweep_last     = (r_ptr == r_hi);

    assign o_status.head_valid = r_head_valid;
    assign o_status.pool_empty = (r_pool_first > hi_clamped);
    assign o_status.sweep_last = sweep_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_first <= '0;
            r_pool_last  <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POOL_FIRST: r_pool_first <= i_cfg_data;
                CFG_POOL_LAST:  r_pool_last  <= i_cfg_data;
                default:        r_pool_first <= r_pool_first;
            endcase
        end
    end

    // A free pushes the old head below the returned frame; the sweep links
    // each pool frame to the next one up.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(i_frame_in);
        mem_wdata.valid = r_head_valid;
        mem_wdata.frame = r_head;
        if (i_cmd.free_push && frame_in_range) begin
            mem_we = 1'b1;
        end else if (i_cmd.sweep) begin
            mem_we          = 1'b1;
            mem_waddr       = AW'(r_ptr);
            mem_wdata.valid = !sweep_last;
            mem_wdata.frame = sweep_last ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.read_head) begin
            r_rd_link <= mem[AW'(r_head)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_head_valid <= 1'b0;
        end else if (i_cmd.free_push && frame_in_range) begin
            r_head       <= i_frame_in;
            r_head_valid <= 1'b1;
        end else if (i_cmd.pop) begin
            r_head       <= r_rd_link.frame;
            r_head_valid <= r_rd_link.valid;
        end else if (i_cmd.clear_head) begin
            r_head       <= '0;
            r_head_valid <= 1'b0;
        end else if (i_cmd.sweep && sweep_last) begin
            r_head       <= r_pool_first;
            r_head_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_load) begin
            r_ptr <= r_pool_first;
            r_hi  <= hi_clamped;
        end else if (i_cmd.sweep) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_frame_out <= i_cmd.pop ? r_head : '0;
            r_status    <= i_cmd.fail;
        end
    end

    assign o_done          = r_done;
    assign o_frame_out     = r_frame_out;
    assign o_result_status = r_status;

endmodule

@@ hw/rtl/frame_free_list_allocator_unit.sv @@
// Frame free-list allocator: LIFO free list of page-sized physical frames.
// Usage:
//   A request is taken at a rising edge with start high and busy low. i_cmd
//   selects alloc, free (of i_frame_in), init over the configured pool, or
//   no operation. Every request gives exactly one result: o_done is high for
//   one cycle with o_frame_out and o_status. The receiver cannot stall, so a
//   result must be taken in the cycle it is shown.
//   Free, no operation, init of an empty pool and alloc on an empty list give
//   their result in the cycle after the request and leave busy low: one
//   request per cycle. Alloc reads the next link from the link memory, pops
//   the head in the pop state and registers its result from there; busy is
//   high for one cycle. Init writes one link per cycle over the pool with
//   busy high, and registers its result after the last link is written.
//   The user writes the pool bounds through the configuration channel
//   (index 0 lowest frame, index 1 highest frame) while no request is in
//   flight; the block does not enforce this. o_cfg_ready is always high.
//   Synchronous reset empties the list and sets the pool to all frames. The
//   link memory is not cleared; every entry is written before it is read.
// Depends on ffla_pkg, ffla_ctrl and ffla_datapath.
module frame_free_list_allocator_unit
    import ffla_pkg::*;
#(
    parameter int NUM_FRAMES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [FRAME_W-1:0] i_frame_in,
    output logic               o_done,
    output logic [FRAME_W-1:0] o_frame_out,
    output logic               o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [FRAME_W-1:0] i_cfg_data
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // The pool registers can always take a write.
    assign o_cfg_ready = 1'b1;

    ffla_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (t_cmd'(i_cmd)),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd),
        .o_busy   (busy)
    );

    ffla_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_frame_in      (i_frame_in),
        .i_cmd           (ctrl_cmd),
        .o_status        (dp_status),
        .o_done          (o_done),
        .o_frame_out     (o_frame_out),
        .o_result_status (o_status)
    );

endmodule

@@ hw/rtl/ffla_checker.sv @@
// Port-level checks for the frame free-list allocator, bound to the top level.
// Depends on ffla_pkg and frame_free_list_allocator_unit.
module ffla_checker
    import ffla_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_cmd,
    input logic               o_done,
    input logic [FRAME_W-1:0] o_frame_out,
    input logic               o_status
);

    // Reset leaves no result pending and the block ready.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_done && !busy)
        else $error("result or busy after reset");

    // A result is shown only once the block has finished its work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !busy)
        else $error("result shown while busy");

    // A free request gives a plain ok result in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd == CMD_FREE |=> o_done && !o_status && o_frame_out == '0)
        else $error("free request gave a wrong result");

    // Every result comes from a request or from finishing work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) || $past(start))
        else $error("result without request");

endmodule

bind frame_free_list_allocator_unit ffla_checker u_ffla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_done      (o_done),
    .o_frame_out (o_frame_out),
    .o_status    (o_status)
);
